/* src/nta_pkg.sv */
// ----------------------------------------------------------------------------
// nta_pkg
// Shared types, sizes and helpers for the neighbor table with heartbeat aging.
// ----------------------------------------------------------------------------
package nta_pkg;

  localparam int NodeCount  = 5;
  localparam int TableDepth = 16;
  localparam int AdvFields  = 5;

  localparam int IdW     = $clog2(NodeCount);
  localparam int AddrW   = $clog2(TableDepth);
  localparam int CntW    = $clog2(TableDepth + 1);
  localparam int AgeW    = 8;
  localparam int MaskW   = 8;
  localparam int CfgIdxW = 1;

  localparam logic [AgeW-1:0] AgeMax = '1;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgOwnId     = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgThreshold = 1'b1;

  localparam logic [2:0]      OwnIdRst     = 3'd0;
  localparam logic [AgeW-1:0] ThresholdRst = 8'd4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic [IdW-1:0]  id;
    logic [AgeW-1:0] age;
  } entry_t;

  typedef struct packed {
    logic         en;
    logic [AddrW-1:0] addr;
    entry_t       data;
  } mem_wr_t;

  typedef struct packed {
    logic       en;
    logic [AddrW-1:0] addr;
  } mem_rd_t;

  typedef struct packed {
    logic       action;
    logic [7:0] sender_id;
    logic [7:0] adv_mask_0;
    logic [7:0] adv_mask_1;
    logic [7:0] adv_mask_2;
    logic [7:0] adv_mask_3;
    logic [7:0] adv_mask_4;
  } in_item_t;

  typedef struct packed {
    logic [4:0] neighbor_count;
    logic [4:0] local_mask;
    logic [2:0] cardinality;
    logic [7:0] stored_mask_0;
    logic [7:0] stored_mask_1;
    logic [7:0] stored_mask_2;
    logic [7:0] stored_mask_3;
    logic [7:0] stored_mask_4;
  } out_item_t;

  // one-hot membership bit for a node id, zero when the id is out of range
  function automatic logic [MaskW-1:0] id_bit(input logic [7:0] id);
    logic [MaskW-1:0] m;
    m = '0;
    for (int i = 0; i < NodeCount; i++) begin
      if (id == 8'(i)) begin
        m[i] = 1'b1;
      end
    end
    return m;
  endfunction

endpackage

/* src/nta_mem.sv */
// ----------------------------------------------------------------------------
// nta_mem
// Neighbor table storage: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module nta_mem (
  input  logic             clk_i,
  input  nta_pkg::mem_rd_t rd_i,
  input  nta_pkg::mem_wr_t wr_i,
  output nta_pkg::entry_t  rd_data_o
);

  nta_pkg::entry_t mem_q [nta_pkg::TableDepth];
  nta_pkg::entry_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_i.en) begin
      rd_data_q <= mem_q[rd_i.addr];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* src/neighbor_table_with_heartbeat_aging.sv */
// ----------------------------------------------------------------------------
// neighbor_table_with_heartbeat_aging
// Neighbor id table with heartbeat aging, per-node membership masks and
// group size estimate.
// ----------------------------------------------------------------------------
// Usage:
//   An item (message or heartbeat tick) is taken on a rising edge with
//   start_i high and busy_o low. busy_o stays high until the result has
//   been shown. Each item gives exactly one result on result_o, marked by
//   done_o for one cycle; the receiver has no way to hold it off.
//   Config: cfg_we_i writes cfg_data_i into register cfg_idx_i (0 = own id,
//   1 = contact threshold) on the same edge. The user must write only while
//   busy_o is low; the block itself does not enforce this.
// Processing (N = entries in the table when the item arrives):
//   An item takes one pass over the N table entries, with one read issued
//   per cycle and a read-modify-write of the previous entry in the same
//   cycle, then the FINISH and OUT states. A tick compacts in that same
//   pass (separate read and write pointers).
// Reset:
//   rst_ni clears the entry count, masks and registers. The table memory
//   itself is not cleared: only the first entry_count entries are ever read.
// ----------------------------------------------------------------------------
module neighbor_table_with_heartbeat_aging (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  output logic                               busy_o,
  input  nta_pkg::in_item_t                  item_i,
  output logic                               done_o,
  output nta_pkg::out_item_t                 result_o,
  input  logic                               cfg_we_i,
  input  logic [nta_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [7:0]                         cfg_data_i
);

  // control
  nta_pkg::state_e state_q, state_d;

  // config registers
  logic [2:0]               own_q;
  logic [nta_pkg::AgeW-1:0] thr_q;

  // item state
  nta_pkg::in_item_t         req_q, req_d;
  logic                      msg_ok_q, msg_ok_d;   // message with valid sender
  logic [nta_pkg::CntW-1:0]  count_q, count_d;
  logic [nta_pkg::CntW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [nta_pkg::CntW-1:0]  wr_ptr_q, wr_ptr_d;   // compaction write slot
  logic                      pend_q, pend_d;       // read data arrives this cycle
  logic [nta_pkg::AddrW-1:0] pend_idx_q, pend_idx_d;
  logic                      found_q, found_d;
  logic [nta_pkg::MaskW-1:0] lbits_q, lbits_d;     // own mask being rebuilt
  logic [nta_pkg::MaskW-1:0] masks_q [nta_pkg::NodeCount];
  logic [nta_pkg::MaskW-1:0] masks_d [nta_pkg::NodeCount];

  // table memory
  nta_pkg::mem_rd_t mem_rd;
  nta_pkg::mem_wr_t mem_wr;
  nta_pkg::entry_t  rd_e;

  logic issue;
  logic [7:0] adv [nta_pkg::AdvFields];

  nta_mem u_mem (
    .clk_i     (clk_i),
    .rd_i      (mem_rd),
    .wr_i      (mem_wr),
    .rd_data_o (rd_e)
  );

  assign adv[0] = item_i.adv_mask_0;
  assign adv[1] = item_i.adv_mask_1;
  assign adv[2] = item_i.adv_mask_2;
  assign adv[3] = item_i.adv_mask_3;
  assign adv[4] = item_i.adv_mask_4;

  // a new read goes out while unread entries remain
  assign issue = (state_q == nta_pkg::ST_SCAN) && (rd_ptr_q < count_q);

  // ---------------------------------------------------------------- next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      nta_pkg::ST_IDLE: begin
        if (start_i) begin
          state_d = nta_pkg::ST_SCAN;
        end
      end
      nta_pkg::ST_SCAN: begin
        // last pending entry is handled in this same cycle
        if (!issue) begin
          state_d = nta_pkg::ST_FINISH;
        end
      end
      nta_pkg::ST_FINISH: begin
        state_d = nta_pkg::ST_OUT;
      end
      nta_pkg::ST_OUT: begin
        state_d = nta_pkg::ST_IDLE;
      end
      default: begin
        state_d = nta_pkg::ST_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------- datapath
  always_comb begin
    logic [nta_pkg::AgeW-1:0]  age_nx;
    logic [nta_pkg::MaskW-1:0] lb;

    req_d      = req_q;
    msg_ok_d   = msg_ok_q;
    count_d    = count_q;
    rd_ptr_d   = rd_ptr_q;
    wr_ptr_d   = wr_ptr_q;
    pend_d     = 1'b0;
    pend_idx_d = pend_idx_q;
    found_d    = found_q;
    lbits_d    = lbits_q;
    masks_d    = masks_q;
    mem_rd     = '{en: issue, addr: rd_ptr_q[nta_pkg::AddrW-1:0]};
    mem_wr     = '0;
    age_nx     = '0;
    lb         = lbits_q;

    case (state_q)
      nta_pkg::ST_IDLE: begin
        if (start_i) begin
          req_d    = item_i;
          msg_ok_d = !item_i.action && (item_i.sender_id < 8'(nta_pkg::NodeCount));
          rd_ptr_d = '0;
          wr_ptr_d = '0;
          found_d  = 1'b0;
          lbits_d  = '0;
          // copy advertised masks, all but our own
          if (!item_i.action && (item_i.sender_id < 8'(nta_pkg::NodeCount))) begin
            for (int i = 0; i < nta_pkg::NodeCount; i++) begin
              if (8'(own_q) != 8'(i)) begin
                masks_d[i] = (i < nta_pkg::AdvFields) ? adv[i] : '0;
              end
            end
          end
        end
      end

      nta_pkg::ST_SCAN: begin
        if (issue) begin
          rd_ptr_d   = rd_ptr_q + 1'b1;
          pend_d     = 1'b1;
          pend_idx_d = rd_ptr_q[nta_pkg::AddrW-1:0];
        end
        if (pend_q) begin
          if (req_q.action) begin
            // tick: age with saturation, drop or move down to the write slot
            age_nx = (rd_e.age == nta_pkg::AgeMax) ? rd_e.age : rd_e.age + 1'b1;
            if (age_nx >= thr_q) begin
              for (int i = 0; i < nta_pkg::NodeCount; i++) begin
                if (8'(rd_e.id) == 8'(i)) begin
                  masks_d[i] = '0;
                end
              end
            end else begin
              mem_wr   = '{en: 1'b1, addr: wr_ptr_q[nta_pkg::AddrW-1:0],
                           data: '{id: rd_e.id, age: age_nx}};
              wr_ptr_d = wr_ptr_q + 1'b1;
              lbits_d  = lbits_q | nta_pkg::id_bit(8'(rd_e.id));
            end
          end else begin
            // message: refresh the sender's age
            if (msg_ok_q && (8'(rd_e.id) == req_q.sender_id)) begin
              mem_wr  = '{en: 1'b1, addr: pend_idx_q,
                          data: '{id: rd_e.id, age: '0}};
              found_d = 1'b1;
            end
            lbits_d = lbits_q | nta_pkg::id_bit(8'(rd_e.id));
          end
        end
      end

      nta_pkg::ST_FINISH: begin
        if (req_q.action) begin
          count_d = wr_ptr_q;
        end else if (msg_ok_q && !found_q &&
                     (count_q < nta_pkg::CntW'(nta_pkg::TableDepth))) begin
          // append new neighbor at the tail
          mem_wr  = '{en: 1'b1, addr: count_q[nta_pkg::AddrW-1:0],
                      data: '{id: req_q.sender_id[nta_pkg::IdW-1:0], age: '0}};
          count_d = count_q + 1'b1;
          lb      = lb | nta_pkg::id_bit(req_q.sender_id);
        end
        lb = lb | nta_pkg::id_bit(8'(own_q));
        for (int i = 0; i < nta_pkg::NodeCount; i++) begin
          if (8'(own_q) == 8'(i)) begin
            masks_d[i] = lb;
          end
        end
        lbits_d = lb;
      end

      default: begin
      end
    endcase
  end

  // ---------------------------------------------------------------- outputs
  always_comb begin
    logic [nta_pkg::MaskW-1:0] all_m;
    logic [3:0]                pc;
    logic [7:0]                so [nta_pkg::AdvFields];

    all_m = '0;
    pc    = '0;
    for (int i = 0; i < nta_pkg::AdvFields; i++) begin
      so[i] = '0;
    end
    for (int i = 0; i < nta_pkg::NodeCount; i++) begin
      all_m = all_m | masks_q[i];
    end
    for (int i = 0; i < nta_pkg::NodeCount; i++) begin
      pc = pc + 4'(all_m[i]);
    end
    if (pc == '0) begin
      pc = 4'd1;
    end
    for (int i = 0; i < nta_pkg::NodeCount && i < nta_pkg::AdvFields; i++) begin
      so[i] = masks_q[i];
    end

    busy_o                  = (state_q != nta_pkg::ST_IDLE);
    done_o                  = (state_q == nta_pkg::ST_OUT);
    result_o.neighbor_count = 5'(count_q);
    result_o.local_mask     = lbits_q[4:0];
    result_o.cardinality    = pc[2:0];
    result_o.stored_mask_0  = so[0];
    result_o.stored_mask_1  = so[1];
    result_o.stored_mask_2  = so[2];
    result_o.stored_mask_3  = so[3];
    result_o.stored_mask_4  = so[4];
  end

  // ---------------------------------------------------------------- registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= nta_pkg::ST_IDLE;
      count_q  <= '0;
      rd_ptr_q <= '0;
      wr_ptr_q <= '0;
      pend_q   <= 1'b0;
      found_q  <= 1'b0;
      msg_ok_q <= 1'b0;
      lbits_q  <= '0;
      for (int i = 0; i < nta_pkg::NodeCount; i++) begin
        masks_q[i] <= '0;
      end
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      rd_ptr_q <= rd_ptr_d;
      wr_ptr_q <= wr_ptr_d;
      pend_q   <= pend_d;
      found_q  <= found_d;
      msg_ok_q <= msg_ok_d;
      lbits_q  <= lbits_d;
      masks_q  <= masks_d;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    req_q      <= req_d;
    pend_idx_q <= pend_idx_d;
  end

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_q <= nta_pkg::OwnIdRst;
      thr_q <= nta_pkg::ThresholdRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        nta_pkg::CfgOwnId:     own_q <= cfg_data_i[2:0];
        nta_pkg::CfgThreshold: thr_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // ---------------------------------------------------------------- checks
  // scan write never lands on the entry being read in the same cycle
  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_wr.en && mem_rd.en) |-> (mem_wr.addr != mem_rd.addr))
    else $error("table write and read hit the same entry");

  // compaction slot never passes the read pointer
  a_wr_behind_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == nta_pkg::ST_SCAN) |-> (wr_ptr_q <= rd_ptr_q))
    else $error("compaction pointer ahead of read pointer");

  // entry count stays within the table
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (count_q <= nta_pkg::CntW'(nta_pkg::TableDepth)))
    else $error("entry count beyond table depth");

  // result strobe is followed by a return to idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> (!busy_o && !done_o))
    else $error("block not idle after result");

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the neighbor table with heartbeat aging. Messages
// and heartbeat ticks go in through the start/busy handshake. A local model
// keeps its own table, ages and node masks, and predicts every result. Each
// done_o strobe is compared field by field with the oldest prediction. Both
// registers are rewritten between phases, and only while the block is idle.
// ----------------------------------------------------------------------------
module tb_top;

  // item kinds carried in the action field
  localparam logic ActMessage = 1'b0;
  localparam logic ActTick    = 1'b1;

  // sized for the worst-case item time plus sender gaps, with a wide margin
  localparam int CycleLimit = 400000;
  localparam int MaxPrints  = 40;
  localparam int PhaseItems = 355;

  logic                        clk_i      = 1'b0;
  logic                        rst_ni     = 1'b0;
  logic                        start_i    = 1'b0;
  nta_pkg::in_item_t           item_i     = '0;
  logic                        cfg_we_i   = 1'b0;
  logic [nta_pkg::CfgIdxW-1:0] cfg_idx_i  = '0;
  logic [7:0]                  cfg_data_i = '0;
  logic                        busy_o;
  logic                        done_o;
  nta_pkg::out_item_t          result_o;

  neighbor_table_with_heartbeat_aging DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .item_i     (item_i),
    .done_o     (done_o),
    .result_o   (result_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // 4 ns clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Local copy of the table state and registers
  // --------------------------------------------------------------------------
  logic [2:0] tbl_id    [nta_pkg::TableDepth];
  logic [7:0] tbl_age   [nta_pkg::TableDepth];
  int         tbl_count;
  logic [7:0] node_mask [nta_pkg::NodeCount];
  logic [2:0] own_id_q;
  logic [7:0] threshold_q;

  nta_pkg::out_item_t pending_results[$];
  nta_pkg::out_item_t want_r;

  int send_idle_pct;
  int n_items     = 0;
  int n_results   = 0;
  int n_errors    = 0;
  int n_cfg       = 0;
  int n_drops     = 0;
  int cycle_count = 0;

  task automatic clear_table_model();
    for (int i = 0; i < nta_pkg::TableDepth; i++) begin
      tbl_id[i]  = '0;
      tbl_age[i] = '0;
    end
    for (int i = 0; i < nta_pkg::NodeCount; i++) begin
      node_mask[i] = '0;
    end
    tbl_count   = 0;
    own_id_q    = nta_pkg::OwnIdRst;
    threshold_q = nta_pkg::ThresholdRst;
  endtask

  // Applies one item to the local table and returns the result it gives.
  function automatic nta_pkg::out_item_t table_update(input nta_pkg::in_item_t it);
    logic [7:0]         adv [nta_pkg::AdvFields];
    logic [4:0]         own_bits;
    logic [7:0]         group;
    nta_pkg::out_item_t r;
    bit                 found;
    int                 i;
    int                 pop;
    adv[0] = it.adv_mask_0;
    adv[1] = it.adv_mask_1;
    adv[2] = it.adv_mask_2;
    adv[3] = it.adv_mask_3;
    adv[4] = it.adv_mask_4;
    if (it.action == ActMessage) begin
      // unknown senders leave table and masks untouched
      if (it.sender_id < nta_pkg::NodeCount) begin
        for (i = 0; i < nta_pkg::NodeCount; i++) begin
          if (i != own_id_q) begin
            node_mask[i] = adv[i];
          end
        end
        found = 1'b0;
        for (i = 0; i < tbl_count; i++) begin
          if (tbl_id[i] == it.sender_id[2:0]) begin
            tbl_age[i] = '0;
            found      = 1'b1;
          end
        end
        if (!found && tbl_count < nta_pkg::TableDepth) begin
          tbl_id[tbl_count]  = it.sender_id[2:0];
          tbl_age[tbl_count] = '0;
          tbl_count++;
        end
      end
    end else begin
      for (i = 0; i < tbl_count; i++) begin
        if (tbl_age[i] != nta_pkg::AgeMax) begin
          tbl_age[i]++;
        end
      end
      // drop stale entries, closing the gap each time
      i = 0;
      while (i < tbl_count) begin
        if (tbl_age[i] >= threshold_q) begin
          if (tbl_id[i] < nta_pkg::NodeCount) begin
            node_mask[tbl_id[i]] = '0;
          end
          for (int k = i; k + 1 < tbl_count; k++) begin
            tbl_id[k]  = tbl_id[k + 1];
            tbl_age[k] = tbl_age[k + 1];
          end
          tbl_id[tbl_count - 1]  = '0;
          tbl_age[tbl_count - 1] = '0;
          tbl_count--;
          n_drops++;
        end else begin
          i++;
        end
      end
    end
    own_bits = '0;
    for (i = 0; i < tbl_count; i++) begin
      if (tbl_id[i] < nta_pkg::NodeCount) begin
        own_bits[tbl_id[i]] = 1'b1;
      end
    end
    if (own_id_q < nta_pkg::NodeCount) begin
      own_bits[own_id_q]  = 1'b1;
      node_mask[own_id_q] = {3'b000, own_bits};
    end
    group = '0;
    for (i = 0; i < nta_pkg::NodeCount; i++) begin
      group |= node_mask[i];
    end
    pop = 0;
    for (i = 0; i < nta_pkg::NodeCount; i++) begin
      pop += group[i];
    end
    if (pop < 1) begin
      pop = 1;
    end
    r.neighbor_count = 5'(tbl_count);
    r.local_mask     = own_bits;
    r.cardinality    = 3'(pop);
    r.stored_mask_0  = node_mask[0];
    r.stored_mask_1  = node_mask[1];
    r.stored_mask_2  = node_mask[2];
    r.stored_mask_3  = node_mask[3];
    r.stored_mask_4  = node_mask[4];
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Result checking: every done_o strobe pairs with the oldest prediction
  // --------------------------------------------------------------------------
  task automatic compare_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
    if (want !== got) begin
      n_errors++;
      if (n_errors <= MaxPrints) begin
        $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        n_errors++;
        if (n_errors <= MaxPrints) begin
          $display("%0t ns: result with no item outstanding, expected none, actual %h",
                   $time, result_o);
        end
      end else begin
        want_r = pending_results.pop_front();
        n_results++;
        compare_field("neighbor_count", 8'(want_r.neighbor_count),
                      8'(result_o.neighbor_count));
        compare_field("local_mask", 8'(want_r.local_mask), 8'(result_o.local_mask));
        compare_field("cardinality", 8'(want_r.cardinality), 8'(result_o.cardinality));
        compare_field("stored_mask_0", want_r.stored_mask_0, result_o.stored_mask_0);
        compare_field("stored_mask_1", want_r.stored_mask_1, result_o.stored_mask_1);
        compare_field("stored_mask_2", want_r.stored_mask_2, result_o.stored_mask_2);
        compare_field("stored_mask_3", want_r.stored_mask_3, result_o.stored_mask_3);
        compare_field("stored_mask_4", want_r.stored_mask_4, result_o.stored_mask_4);
      end
    end
  end

  // hang guard
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Driving helpers. All of them start and end just after a falling edge.
  // --------------------------------------------------------------------------

  // random bits across the whole payload
  function automatic nta_pkg::in_item_t rand_payload();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return nta_pkg::in_item_t'(r[$bits(nta_pkg::in_item_t)-1:0]);
  endfunction

  // Offers one item, waits for the edge that takes it, then predicts.
  task automatic send_item(input nta_pkg::in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk_i);
    end
    start_i = 1'b1;
    item_i  = it;
    do @(posedge clk_i); while (busy_o);
    pending_results.push_back(table_update(it));
    n_items++;
    @(negedge clk_i);
    start_i = 1'b0;
    item_i  = rand_payload();
  endtask

  // Hold off until every result is back and the block has dropped busy.
  task automatic wait_idle();
    while (pending_results.size() != 0 || busy_o) begin
      @(negedge clk_i);
    end
  endtask

  task automatic write_reg(input logic [nta_pkg::CfgIdxW-1:0] idx,
                           input logic [7:0] data);
    wait_idle();
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = data;
    @(negedge clk_i);
    cfg_we_i   = 1'b0;
    cfg_idx_i  = 1'($urandom);
    cfg_data_i = 8'($urandom);
    if (idx == nta_pkg::CfgOwnId) begin
      own_id_q = data[2:0];
    end else begin
      threshold_q = data;
    end
    n_cfg++;
  endtask

  // masks are {node 0, node 1, node 2, node 3, node 4}, node 0 uppermost
  function automatic nta_pkg::in_item_t msg_item(input logic [7:0] sender,
                                                 input logic [39:0] masks);
    return nta_pkg::in_item_t'({ActMessage, sender, masks});
  endfunction

  // sender and masks are don't-care on a tick; keep them random
  function automatic nta_pkg::in_item_t tick_item();
    nta_pkg::in_item_t it;
    it        = rand_payload();
    it.action = ActTick;
    return it;
  endfunction

  function automatic logic [7:0] rand_mask();
    int roll;
    roll = $urandom_range(99);
    if (roll < 10) begin
      return 8'h00;
    end else if (roll < 20) begin
      return 8'hFF;
    end
    return 8'($urandom);
  endfunction

  function automatic nta_pkg::in_item_t rand_item(input int tick_pct, input int bad_pct);
    nta_pkg::in_item_t it;
    if ($urandom_range(99) < tick_pct) begin
      it = tick_item();
    end else begin
      it.action = ActMessage;
      if ($urandom_range(99) < bad_pct) begin
        it.sender_id = 8'($urandom_range(255, nta_pkg::NodeCount));
      end else begin
        it.sender_id = 8'($urandom_range(nta_pkg::NodeCount - 1));
      end
      it.adv_mask_0 = rand_mask();
      it.adv_mask_1 = rand_mask();
      it.adv_mask_2 = rand_mask();
      it.adv_mask_3 = rand_mask();
      it.adv_mask_4 = rand_mask();
    end
    return it;
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset registers: own id 0, threshold 4. Empty tick, sender equal to own
  // id, unknown senders at both ends of the invalid range, and a refresh.
  task automatic test_reset_state();
    send_item(tick_item());
    send_item(msg_item(8'd0, {5{8'hFF}}));
    send_item(msg_item(8'd4, {5{8'h00}}));
    send_item(msg_item(8'd255, {5{8'hFF}}));
    send_item(msg_item(8'd5, {8'h12, 8'h34, 8'h56, 8'h78, 8'h9A}));
    send_item(msg_item(8'd4, {8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA}));
  endtask

  // Threshold 4: a refreshed neighbor outlives the one that went quiet.
  task automatic test_aging();
    send_item(msg_item(8'd1, {8'h03, 8'h00, 8'h1F, 8'h00, 8'h0F}));
    send_item(msg_item(8'd3, {8'h00, 8'h08, 8'h00, 8'h10, 8'h00}));
    send_item(tick_item());
    send_item(tick_item());
    send_item(msg_item(8'd1, {8'h01, 8'h02, 8'h04, 8'h08, 8'h10}));
    send_item(tick_item());
    send_item(tick_item());
    send_item(tick_item());
    send_item(tick_item());
  endtask

  // Threshold 1, zero threshold, and 255 where the ages run to the top.
  task automatic test_threshold_edges();
    write_reg(nta_pkg::CfgThreshold, 8'd1);
    send_item(msg_item(8'd2, {8'h04, 8'h04, 8'h04, 8'h04, 8'h04}));
    send_item(tick_item());
    write_reg(nta_pkg::CfgThreshold, 8'd0);
    send_item(msg_item(8'd0, {8'h1F, 8'h00, 8'h00, 8'h00, 8'h00}));
    send_item(msg_item(8'd4, {8'h00, 8'h00, 8'h00, 8'h00, 8'h10}));
    send_item(tick_item());
    write_reg(nta_pkg::CfgThreshold, 8'd255);
    for (int s = 0; s < nta_pkg::NodeCount; s++) begin
      send_item(msg_item(8'(s), {5{8'h1F}}));
    end
    for (int t = 0; t < 256; t++) begin
      send_item(tick_item());
    end
    write_reg(nta_pkg::CfgThreshold, nta_pkg::ThresholdRst);
  endtask

  // Top own id, then own ids with no self bit at all.
  task automatic test_own_id();
    write_reg(nta_pkg::CfgOwnId, 8'd4);
    send_item(msg_item(8'd4, {5{8'hFF}}));
    send_item(msg_item(8'd1, {8'h11, 8'h22, 8'h33, 8'h44, 8'h55}));
    write_reg(nta_pkg::CfgOwnId, 8'd7);
    send_item(msg_item(8'd0, {8'h81, 8'h42, 8'h24, 8'h18, 8'hFF}));
    send_item(tick_item());
    write_reg(nta_pkg::CfgOwnId, 8'd5);
    send_item(msg_item(8'd3, {8'h01, 8'h02, 8'h04, 8'h08, 8'h10}));
    write_reg(nta_pkg::CfgOwnId, 8'(nta_pkg::OwnIdRst));
  endtask

  // Random traffic in segments. Each segment gets fresh registers (written
  // only once the block has drained) and its own mix of ticks and bad ids.
  task automatic test_random_traffic(input int count);
    int sent;
    int seg_len;
    int tick_pct;
    int bad_pct;
    int roll;
    logic [7:0] thr;
    logic [2:0] own;
    sent = 0;
    while (sent < count) begin
      roll = $urandom_range(99);
      if (roll < 60) begin
        thr = 8'($urandom_range(6, 1));
      end else if (roll < 75) begin
        thr = 8'($urandom_range(40, 7));
      end else if (roll < 85) begin
        thr = 8'd255;
      end else if (roll < 95) begin
        thr = 8'd1;
      end else begin
        thr = 8'd0;
      end
      if ($urandom_range(99) < 80) begin
        own = 3'($urandom_range(nta_pkg::NodeCount - 1));
      end else begin
        own = 3'($urandom_range(7, nta_pkg::NodeCount));
      end
      // only the low three bits of the data hold the own id
      write_reg(nta_pkg::CfgOwnId, {5'($urandom), own});
      write_reg(nta_pkg::CfgThreshold, thr);
      seg_len  = $urandom_range(60, 20);
      tick_pct = $urandom_range(50, 10);
      bad_pct  = $urandom_range(15, 0);
      for (int n = 0; n < seg_len && sent < count; n++) begin
        send_item(rand_item(tick_pct, bad_pct));
        sent++;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    clear_table_model();
    send_idle_pct = 36;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_state();
    test_aging();
    test_threshold_edges();
    test_own_id();

    test_random_traffic(PhaseItems);
    send_idle_pct = 67;
    test_random_traffic(PhaseItems);
    send_idle_pct = 0;
    test_random_traffic(PhaseItems);

    // drain, then give a stray strobe time to show up
    wait_idle();
    repeat (40) @(negedge clk_i);

    $display("Ran %0d messages and ticks, checked %0d results, %0d register writes.",
             n_items, n_results, n_cfg);
    $display("Neighbors aged out: %0d; field mismatches: %0d.", n_drops, n_errors);
    if (n_errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
